// ----- hdl/dsq_pkg.sv -----
package dsq_pkg;

    // Width of one DShot frame and of the value it carries.
    localparam int FRAME_W = 16;
    localparam int VALUE_W = 11;
    localparam int MAX_LINES = 4;

    // Speed handling: saturation limit and the offset into the throttle range.
    localparam logic [VALUE_W-1:0] SPEED_MAX = 11'd1999;
    localparam logic [VALUE_W-1:0] SPEED_BASE = 11'd48;

    // Last third of a bit and last bit of a frame.
    localparam logic [1:0] LAST_THIRD = 2'd2;
    localparam logic [3:0] LAST_BIT = 4'd15;

    // Toggle pattern over the three thirds of a bit, third 0 in bit 0.
    localparam logic [2:0] TOGGLE_ZERO = 3'b011;
    localparam logic [2:0] TOGGLE_ONE = 3'b101;

    typedef enum logic [1:0] {
        FUNC_TICK    = 2'd0,
        FUNC_COMMAND = 2'd1,
        FUNC_SPEEDS  = 2'd2,
        FUNC_NONE    = 2'd3
    } func_t;

    typedef struct packed {
        func_t                             func;
        logic [VALUE_W-1:0]                command;
        logic [1:0]                        motor;
        logic [MAX_LINES-1:0][VALUE_W-1:0] speed;
    } item_t;

    typedef struct packed {
        logic [MAX_LINES-1:0] line_levels;
        logic                 busy_res;
        logic                 accepted;
    } result_t;

    // Builds a frame: value, a zero telemetry bit, then the nibble checksum.
    function automatic logic [FRAME_W-1:0] build_frame(input logic [VALUE_W-1:0] value);
        logic [VALUE_W:0] shifted;
        logic [3:0]       crc;
        shifted = {value, 1'b0};
        crc = shifted[3:0] ^ shifted[7:4] ^ shifted[11:8];
        return {shifted, crc};
    endfunction

    // Whether a line toggles in the given third of a bit.
    function automatic logic toggle_for(input logic bit_value, input logic [1:0] third);
        logic [2:0] pattern;
        logic       result;
        pattern = bit_value ? TOGGLE_ONE : TOGGLE_ZERO;
        case (third)
            2'd0:    result = pattern[0];
            2'd1:    result = pattern[1];
            2'd2:    result = pattern[2];
            default: result = 1'b0;
        endcase
        return result;
    endfunction

endpackage

// ----- hdl/dsq_frame_builder.sv -----
module dsq_frame_builder (
    input  dsq_pkg::item_t                                              item,
    output logic [dsq_pkg::FRAME_W-1:0]                                 cmd_frame,
    output logic [dsq_pkg::MAX_LINES-1:0][dsq_pkg::FRAME_W-1:0]         speed_frames
);
    import dsq_pkg::*;

    // Command frame straight from the 11-bit value.
    assign cmd_frame = build_frame(item.command);

    // Speed frames: saturate, add the throttle offset, then frame.
    always_comb begin
        logic [VALUE_W-1:0] clipped;
        for (int n = 0; n < MAX_LINES; n++) begin
            clipped = (item.speed[n] > SPEED_MAX) ? SPEED_MAX : item.speed[n];
            speed_frames[n] = build_frame(clipped + SPEED_BASE);
        end
    end

endmodule

// ----- hdl/dsq_line_engine.sv -----
module dsq_line_engine #(
    parameter int NUM_LINES = 4
) (
    input  logic                                                aclk,
    input  logic                                                aresetn,
    input  logic                                                item_valid,
    output logic                                                item_ready,
    input  dsq_pkg::item_t                                      item,
    input  logic [dsq_pkg::FRAME_W-1:0]                         cmd_frame,
    input  logic [dsq_pkg::MAX_LINES-1:0][dsq_pkg::FRAME_W-1:0] speed_frames,
    output logic                                                res_valid,
    input  logic                                                res_ready,
    output dsq_pkg::result_t                                    res
);
    import dsq_pkg::*;

    logic [NUM_LINES-1:0][FRAME_W-1:0] frame_reg;
    logic [NUM_LINES-1:0][FRAME_W-1:0] frame_next;
    logic [MAX_LINES-1:0]              active_reg, active_next;
    logic [3:0]                        bit_index_reg, bit_index_next;
    logic [1:0]                        third_reg, third_next;
    logic                              sending_reg, sending_next;
    logic [MAX_LINES-1:0]              levels_reg, levels_next;
    logic                              valid_reg;
    result_t                           res_reg, res_next;
    logic                              take;
    logic                              motor_ok;
    logic [MAX_LINES-1:0]              toggles;

    // The result register frees up when empty or when its result is taken.
    assign item_ready = !valid_reg || res_ready;
    assign take = item_valid && item_ready;
    assign motor_ok = {1'b0, item.motor} < 3'(NUM_LINES);

    // Toggles for the current third on every active line.
    always_comb begin
        toggles = '0;
        for (int n = 0; n < NUM_LINES; n++) begin
            toggles[n] = active_reg[n] && toggle_for(frame_reg[n][~bit_index_reg], third_reg);
        end
    end

    // Next state and result for the request being taken.
    always_comb begin
        frame_next = frame_reg;
        active_next = active_reg;
        bit_index_next = bit_index_reg;
        third_next = third_reg;
        sending_next = sending_reg;
        levels_next = levels_reg;
        res_next.accepted = 1'b0;
        case (item.func)
            FUNC_TICK: begin
                if (sending_reg) begin
                    levels_next = levels_reg ^ toggles;
                    if (third_reg == LAST_THIRD) begin
                        third_next = '0;
                        if (bit_index_reg == LAST_BIT) begin
                            bit_index_next = '0;
                            sending_next = 1'b0;
                        end else begin
                            bit_index_next = bit_index_reg + 4'd1;
                        end
                    end else begin
                        third_next = third_reg + 2'd1;
                    end
                end
            end
            FUNC_COMMAND: begin
                if (!sending_reg && motor_ok) begin
                    active_next = '0;
                    for (int n = 0; n < NUM_LINES; n++) begin
                        if (item.motor == 2'(n)) begin
                            frame_next[n] = cmd_frame;
                            active_next[n] = 1'b1;
                        end
                    end
                    bit_index_next = '0;
                    third_next = '0;
                    sending_next = 1'b1;
                    res_next.accepted = 1'b1;
                end
            end
            FUNC_SPEEDS: begin
                if (!sending_reg) begin
                    active_next = '0;
                    for (int n = 0; n < NUM_LINES; n++) begin
                        frame_next[n] = speed_frames[n];
                        active_next[n] = 1'b1;
                    end
                    bit_index_next = '0;
                    third_next = '0;
                    sending_next = 1'b1;
                    res_next.accepted = 1'b1;
                end
            end
            default: begin
            end
        endcase
        res_next.line_levels = levels_next;
        res_next.busy_res = sending_next;
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= '0;
            bit_index_reg <= '0;
            third_reg <= '0;
            sending_reg <= 1'b0;
            levels_reg <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (take) begin
                active_reg <= active_next;
                bit_index_reg <= bit_index_next;
                third_reg <= third_next;
                sending_reg <= sending_next;
                levels_reg <= levels_next;
                valid_reg <= 1'b1;
            end else if (res_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Frame words and the result payload.
    always_ff @(posedge aclk) begin
        if (take) begin
            frame_reg <= frame_next;
            res_reg <= res_next;
        end
    end

    assign res_valid = valid_reg;
    assign res = res_reg;

endmodule

// ----- hdl/dshot_quad_transmitter.sv -----
// Four-line DShot transmitter. Each request is a timer tick, a command load for
// one motor, a speeds load for all lines, or a no-op; every request yields
// exactly one result with the line levels, the busy flag and whether a load
// started a frame. A load builds the 16-bit frame (value, zero telemetry bit,
// XOR nibble checksum) and is ignored while a frame is going out; each tick
// then advances one third of a bit, MSB first, so a frame takes 48 ticks. The
// block takes one request per clock cycle; a result passes through the input
// register and the result register, and the stream stalls only when the
// result side holds back tready.
module dshot_quad_transmitter #(
    parameter int NUM_LINES = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // command[10:0], motor[12:11], speed_0[23:13], speed_1[34:24],
    // speed_2[45:35], speed_3[56:46], zero fill [63:57]
    input  logic [63:0] s_tdata,
    // func[1:0]
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // line_levels[3:0], busy_res[4], accepted[5], zero fill [7:6]
    output logic [7:0]  m_tdata
);
    import dsq_pkg::*;

    logic                              in_valid_reg;
    item_t                             in_item_reg;
    item_t                             in_item;
    logic                              eng_ready;
    logic [FRAME_W-1:0]                cmd_frame;
    logic [MAX_LINES-1:0][FRAME_W-1:0] speed_frames;
    result_t                           res;

    // Unpack the incoming request.
    always_comb begin
        in_item.func = func_t'(s_tuser);
        in_item.command = s_tdata[10:0];
        in_item.motor = s_tdata[12:11];
        in_item.speed[0] = s_tdata[23:13];
        in_item.speed[1] = s_tdata[34:24];
        in_item.speed[2] = s_tdata[45:35];
        in_item.speed[3] = s_tdata[56:46];
    end

    // Input register; it refills in the same cycle it hands its request on.
    assign s_tready = !in_valid_reg || eng_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (eng_ready) begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= in_item;
        end
    end

    dsq_frame_builder u_builder (
        .item         (in_item_reg),
        .cmd_frame    (cmd_frame),
        .speed_frames (speed_frames)
    );

    dsq_line_engine #(
        .NUM_LINES (NUM_LINES)
    ) u_engine (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_valid   (in_valid_reg),
        .item_ready   (eng_ready),
        .item         (in_item_reg),
        .cmd_frame    (cmd_frame),
        .speed_frames (speed_frames),
        .res_valid    (m_tvalid),
        .res_ready    (m_tready),
        .res          (res)
    );

    // Pack the result.
    assign m_tdata = {2'b00, res.accepted, res.busy_res, res.line_levels};

endmodule

// ----- tb/tb_dshot_quad_transmitter.sv -----
module tb_dshot_quad_transmitter;
    import dsq_pkg::*;

    localparam int NUM_LINES = 4;
    // Cycles without any transfer before the run is declared hung.
    localparam int HANG_LIMIT = 2000;
    // Cycles to watch for stray results after the last expected one.
    localparam int TAIL_CYCLES = 8;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [7:0]  m_tdata;

    // Transmitter state as the testbench expects it to be.
    logic [15:0] tx_frame [NUM_LINES];
    logic [3:0]  tx_lines = '0;
    logic [3:0]  tx_bit = '0;
    logic [1:0]  tx_third = '0;
    logic        tx_busy = 1'b0;
    logic [3:0]  tx_level = '0;

    result_t     expected_line_reports [$];
    result_t     oldest_report;
    int          fail_count = 0;
    int          quiet_cycles = 0;
    int          stall_left = 0;
    bit          calm = 1'b0;

    dshot_quad_transmitter #(
        .NUM_LINES(NUM_LINES)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // DShot frame: value, zero telemetry bit, XOR of the three nibbles of (value << 1).
    function automatic logic [15:0] frame_of(input logic [10:0] value);
        logic [15:0] word;
        word = {4'd0, value, 1'b0};
        return {word[11:0], word[3:0] ^ word[7:4] ^ word[11:8]};
    endfunction

    // Applies one request to the expected state and returns the report it yields.
    function automatic result_t predict_line_report(input func_t fn, input logic [10:0] cmd,
                                                    input logic [1:0] mot,
                                                    input logic [3:0][10:0] spd);
        result_t     rep;
        logic [3:0]  flips;
        logic [10:0] sat;
        logic        b;
        int          n;
        rep.accepted = 1'b0;
        case (fn)
            FUNC_TICK: begin
                if (tx_busy) begin
                    flips = '0;
                    for (n = 0; n < NUM_LINES; n++) begin
                        if (tx_lines[n]) begin
                            b = tx_frame[n][15 - tx_bit];
                            // A zero bit toggles on thirds 0 and 1, a one bit on 0 and 2.
                            flips[n] = (tx_third == 2'd0) || (tx_third == 2'd1 && !b)
                                       || (tx_third == 2'd2 && b);
                        end
                    end
                    tx_level = tx_level ^ flips;
                    if (tx_third == 2'd2) begin
                        tx_third = 2'd0;
                        if (tx_bit == 4'd15) begin
                            tx_bit = 4'd0;
                            tx_busy = 1'b0;
                        end else begin
                            tx_bit = tx_bit + 4'd1;
                        end
                    end else begin
                        tx_third = tx_third + 2'd1;
                    end
                end
            end
            FUNC_COMMAND: begin
                if (!tx_busy && mot < NUM_LINES) begin
                    tx_frame[mot] = frame_of(cmd);
                    tx_lines = 4'(1 << mot);
                    rep.accepted = 1'b1;
                end
            end
            FUNC_SPEEDS: begin
                if (!tx_busy) begin
                    for (n = 0; n < NUM_LINES; n++) begin
                        sat = (spd[n] > SPEED_MAX) ? SPEED_MAX : spd[n];
                        tx_frame[n] = frame_of(sat + SPEED_BASE);
                    end
                    tx_lines = 4'((1 << NUM_LINES) - 1);
                    rep.accepted = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (rep.accepted) begin
            tx_bit = 4'd0;
            tx_third = 2'd0;
            tx_busy = 1'b1;
        end
        rep.line_levels = tx_level;
        rep.busy_res = tx_busy;
        return rep;
    endfunction

    // Value with a bias toward the ends of the range and the saturation point.
    function automatic logic [10:0] draw_value11();
        case ($urandom_range(0, 7))
            0: return 11'd0;
            1: return 11'h7FF;
            2: return SPEED_MAX;
            default: return 11'($urandom_range(0, 2047));
        endcase
    endfunction

    // Presents one request and records the expected report once it is taken.
    task automatic send_request(input func_t fn, input logic [10:0] cmd, input logic [1:0] mot,
                                input logic [3:0][10:0] spd);
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser <= fn;
        s_tdata <= {7'd0, spd, mot, cmd};
        do @(posedge aclk); while (!s_tready);
        expected_line_reports.push_back(predict_line_report(fn, cmd, mot, spd));
    endtask

    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
    endtask

    task automatic wait_drained();
        idle_sender(1);
        while (expected_line_reports.size() != 0) @(posedge aclk);
    endtask

    // Ticks until the frame in flight has gone out completely.
    task automatic finish_frame();
        while (tx_busy) send_request(FUNC_TICK, '0, '0, '0);
    endtask

    // Ticks and an unused selector while nothing is being sent.
    task automatic test_idle_noop();
        send_request(FUNC_TICK, '0, '0, '0);
        send_request(FUNC_NONE, 11'h7FF, 2'd3, {4{11'h7FF}});
        send_request(FUNC_TICK, 11'h7FF, 2'd3, {4{11'h7FF}});
    endtask

    // Command load on the top line; loads arriving mid-frame must be dropped.
    task automatic test_command_frame();
        send_request(FUNC_COMMAND, 11'h7FF, 2'd3, '0);
        send_request(FUNC_SPEEDS, '0, '0, {11'd5, 11'd6, 11'd7, 11'd8});
        send_request(FUNC_TICK, '0, '0, '0);
        send_request(FUNC_COMMAND, 11'd0, 2'd0, '0);
        send_request(FUNC_NONE, '0, '0, '0);
        finish_frame();
    endtask

    // Speeds at zero, at the limit and above it, which must saturate.
    task automatic test_speed_frame();
        send_request(FUNC_SPEEDS, '0, '0, {11'h7FF, SPEED_MAX, 11'd0, 11'd2000});
        finish_frame();
        send_request(FUNC_COMMAND, 11'd0, 2'd0, '0);
        finish_frame();
    endtask

    // Mostly complete frames with random content, plus dropped loads and noise.
    task automatic test_random_traffic(input int goal);
        int              counted;
        int              pick;
        int              n;
        bit              was_busy;
        bit              pause_due;
        func_t           fn;
        logic [10:0]     cmd;
        logic [1:0]      mot;
        logic [3:0][10:0] spd;
        counted = 0;
        pause_due = 1'b1;
        while (counted < goal) begin
            calm = (counted >= goal * 4 / 5);
            if (!calm && $urandom_range(0, 7) == 0) idle_sender($urandom_range(1, 12));
            if (pause_due && counted >= goal / 3) begin
                pause_due = 1'b0;
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (tx_busy) begin
                fn = (pick < 85) ? FUNC_TICK : (pick < 90) ? FUNC_COMMAND :
                     (pick < 95) ? FUNC_SPEEDS : FUNC_NONE;
            end else begin
                fn = (pick < 45) ? FUNC_COMMAND : (pick < 85) ? FUNC_SPEEDS :
                     (pick < 95) ? FUNC_TICK : FUNC_NONE;
            end
            cmd = draw_value11();
            mot = 2'($urandom_range(0, 3));
            for (n = 0; n < 4; n++) spd[n] = draw_value11();
            was_busy = tx_busy;
            send_request(fn, cmd, mot, spd);
            // Only ticks that move a frame and loads that start one count.
            if ((fn == FUNC_TICK) ? was_busy : (tx_busy && !was_busy)) counted++;
        end
    endtask

    // Result side stalls in bursts, except in the final stretch.
    always @(negedge aclk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 9) == 0) begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 11);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Each report is compared against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_line_reports.size() == 0) begin
                $error("unexpected result: m_tdata %0h with no request pending", m_tdata);
                fail_count++;
            end else begin
                oldest_report = expected_line_reports.pop_front();
                if (m_tdata[3:0] !== oldest_report.line_levels) begin
                    $error("line_levels: expected %0h, got %0h",
                           oldest_report.line_levels, m_tdata[3:0]);
                    fail_count++;
                end
                if (m_tdata[4] !== oldest_report.busy_res) begin
                    $error("busy_res: expected %0b, got %0b", oldest_report.busy_res, m_tdata[4]);
                    fail_count++;
                end
                if (m_tdata[5] !== oldest_report.accepted) begin
                    $error("accepted: expected %0b, got %0b", oldest_report.accepted, m_tdata[5]);
                    fail_count++;
                end
            end
        end
    end

    // Hang detection: no transfer on either side for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= HANG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_idle_noop();
        test_command_frame();
        test_speed_frame();
        test_random_traffic(300);
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_line_reports.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/dsq_pkg.sv
hdl/dsq_frame_builder.sv
hdl/dsq_line_engine.sv
hdl/dshot_quad_transmitter.sv
tb/tb_dshot_quad_transmitter.sv
